// ===== rtl/pic_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Polymorphic inline cache package
// Shared field widths, controller states and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pic_pkg;

    localparam int CFG_W     = 4;
    localparam int CLASS_W   = 32;
    localparam int METHOD_W  = 32;
    localparam int HIT_IDX_W = 3;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_FILL   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESOLVE
    } t_state;

    typedef struct packed {
        logic load;      // latch the request on an input transfer
        logic exec;      // compare entries and apply a fill
        logic out_load;  // move the resolved result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;  // output register holds a result not yet taken
    } t_dp_status;

endpackage : pic_pkg
`default_nettype wire

// ===== rtl/pic_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Polymorphic inline cache controller
// Sequences one request through capture, compare/fill and result resolution.
// ----------------------------------------------------------------------------
module pic_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_ready,
    input  wire pic_pkg::t_dp_status i_status,
    output logic                   o_in_ready,
    output pic_pkg::t_dp_cmd       o_cmd
);

    pic_pkg::t_state r_state;
    pic_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pic_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            pic_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pic_pkg::ST_EXEC;
                end
            end
            pic_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = pic_pkg::ST_RESOLVE;
            end
            pic_pkg::ST_RESOLVE: begin
                // Wait here while an older result still sits unclaimed.
                if (!i_status.out_full || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = pic_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pic_pkg::ST_IDLE;
            end
        endcase
    end

endmodule : pic_ctrl
`default_nettype wire

// ===== rtl/pic_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Polymorphic inline cache datapath
// Entry shift register, parallel tag compare, priority resolve, the
// active-entry register and the output register.
// ----------------------------------------------------------------------------
module pic_datapath #(
    parameter int CACHE_ENTRIES = 8,
    parameter int TAG_BITS      = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire pic_pkg::t_dp_cmd               i_cmd,
    output pic_pkg::t_dp_status                 o_status,
    input  wire logic                           i_cfg_we,
    input  wire logic [pic_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_req_type,
    input  wire logic [pic_pkg::CLASS_W-1:0]    i_class_tag,
    input  wire logic [pic_pkg::METHOD_W-1:0]   i_method_handle,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_hit,
    output logic [pic_pkg::METHOD_W-1:0]        o_found_method,
    output logic [pic_pkg::HIT_IDX_W-1:0]       o_hit_index,
    output logic                                o_stored
);

    localparam int CNT_W        = $clog2(CACHE_ENTRIES + 1);
    localparam int IDX_W        = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CMP_W        = (CNT_W > pic_pkg::CFG_W) ? CNT_W : pic_pkg::CFG_W;
    localparam int RESET_ACTIVE = (CACHE_ENTRIES < 8) ? CACHE_ENTRIES : 8;

    // Request registers
    logic                          r_req_type;
    logic [TAG_BITS-1:0]           r_tag;
    logic [pic_pkg::METHOD_W-1:0]  r_method;

    logic [CNT_W-1:0]              r_active;

    // Entry storage: valid bits are reset, payload is not.
    logic [CACHE_ENTRIES-1:0]      r_valid;
    logic [TAG_BITS-1:0]           r_ent_tag  [CACHE_ENTRIES];
    logic [pic_pkg::METHOD_W-1:0]  r_ent_meth [CACHE_ENTRIES];

    // Compare results carried into the resolve step
    logic [CACHE_ENTRIES-1:0]      r_cand;
    logic [CACHE_ENTRIES-1:0]      r_stop;
    logic                          r_do_store;

    logic [CACHE_ENTRIES-1:0]      n_cand;
    logic [CACHE_ENTRIES-1:0]      n_stop;
    logic [CACHE_ENTRIES-1:0]      in_range;
    logic                          n_do_store;
    logic [CMP_W-1:0]              cfg_ext;
    logic [CNT_W-1:0]              n_active;

    logic                          sel_found;
    logic [IDX_W-1:0]              sel_idx;
    logic                          res_hit;

    assign o_status.out_full = o_out_valid;

    always_comb begin
        cfg_ext = CMP_W'(i_cfg_data);
        if (cfg_ext > CMP_W'(CACHE_ENTRIES)) begin
            n_active = CNT_W'(CACHE_ENTRIES);
        end else begin
            n_active = CNT_W'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CNT_W'(RESET_ACTIVE);
        end else if (i_cfg_we) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_tag      <= TAG_BITS'(i_class_tag);
            r_method   <= i_method_handle;
        end
    end

    // An entry takes part in a search only if it is below the active count;
    // an invalid entry in range ends the search.
    always_comb begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            in_range[i] = (CNT_W'(i) < r_active);
            n_cand[i]   = in_range[i] && r_valid[i] && (r_ent_tag[i] == r_tag);
            n_stop[i]   = in_range[i] && !r_valid[i];
        end
        n_do_store = (r_req_type == pic_pkg::REQ_FILL) && (r_method != '0)
                     && (r_active != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_cand     <= n_cand;
            r_stop     <= n_stop;
            r_do_store <= n_do_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.exec && n_do_store) begin
            for (int i = 1; i < CACHE_ENTRIES; i++) begin
                if (in_range[i]) begin
                    r_valid[i] <= r_valid[i-1];
                end
            end
            r_valid[0] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && n_do_store) begin
            for (int i = 1; i < CACHE_ENTRIES; i++) begin
                if (in_range[i]) begin
                    r_ent_tag[i]  <= r_ent_tag[i-1];
                    r_ent_meth[i] <= r_ent_meth[i-1];
                end
            end
            r_ent_tag[0]  <= r_tag;
            r_ent_meth[0] <= r_method;
        end
    end

    // The lowest entry that either matches or ends the search decides.
    always_comb begin
        sel_found = 1'b0;
        sel_idx   = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            if (r_cand[i] || r_stop[i]) begin
                sel_found = r_cand[i];
                sel_idx   = IDX_W'(i);
            end
        end
        res_hit = sel_found && (r_req_type == pic_pkg::REQ_LOOKUP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_hit          <= res_hit;
            o_found_method <= res_hit ? r_ent_meth[sel_idx] : '0;
            o_hit_index    <= res_hit ? pic_pkg::HIT_IDX_W'(sel_idx) : '0;
            o_stored       <= r_do_store;
        end
    end

endmodule : pic_datapath
`default_nettype wire

// ===== rtl/polymorphic_inline_cache.sv =====
// A request passes through the request, compare-result and output registers before its
// result is valid. No new request is taken until the capture, compare/fill and resolve
// steps of the last one are done; resolve waits while the output is stalled. A new
// request is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) empties the cache by clearing the valid bits, sets
// the active entry count to min(CACHE_ENTRIES, 8), and no clearing pass follows.
`default_nettype none
// ----------------------------------------------------------------------------
// Polymorphic inline cache
// Maps a class tag to a method handle with a small shift-in associative store.
// ----------------------------------------------------------------------------
module polymorphic_inline_cache #(
    parameter int CACHE_ENTRIES = 8,
    parameter int TAG_BITS      = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [pic_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_req_type,
    input  wire logic [pic_pkg::CLASS_W-1:0]    i_class_tag,
    input  wire logic [pic_pkg::METHOD_W-1:0]   i_method_handle,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_hit,
    output logic [pic_pkg::METHOD_W-1:0]        o_found_method,
    output logic [pic_pkg::HIT_IDX_W-1:0]       o_hit_index,
    output logic                                o_stored
);

    pic_pkg::t_dp_cmd    cmd;
    pic_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    pic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    pic_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .TAG_BITS      (TAG_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_class_tag     (i_class_tag),
        .i_method_handle (i_method_handle),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_hit           (o_hit),
        .o_found_method  (o_found_method),
        .o_hit_index     (o_hit_index),
        .o_stored        (o_stored)
    );

endmodule : polymorphic_inline_cache
`default_nettype wire

// ===== rtl/pic_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Polymorphic inline cache port checker
// Watches the top-level ports for result encoding and handshake timing.
// ----------------------------------------------------------------------------
module pic_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           o_in_ready,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic                           o_hit,
    input  wire logic [pic_pkg::METHOD_W-1:0]   o_found_method,
    input  wire logic [pic_pkg::HIT_IDX_W-1:0]  o_hit_index,
    input  wire logic                           o_stored
);

    logic in_xfer;

    assign in_xfer = i_in_valid && o_in_ready;

    // A result waiting for the consumer must not change or disappear.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found_method)
        && $stable(o_hit) && $stable(o_hit_index) && $stable(o_stored))
        else $error("result changed while stalled");

    // A result is never both a lookup hit and a completed fill.
    a_hit_store_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_stored))
        else $error("hit and stored both set");

    // Without a hit the method and index fields read zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> (o_found_method == '0) && (o_hit_index == '0))
        else $error("miss result carries nonzero method or index");

    // A request occupies the engine for its compare and resolve steps.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready ##1 !o_in_ready)
        else $error("new request taken while one is in flight");

endmodule : pic_checker

bind polymorphic_inline_cache pic_checker u_pic_checker (.*);
`default_nettype wire
